>>> sv/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg: shared types and constants
// Queue item layout, MD5 initial chaining values and per-round tables.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } md5_item_t;

  localparam logic [31:0] CHAIN_A  = 32'h67452301;
  localparam logic [31:0] CHAIN_B  = 32'hefcdab89;
  localparam logic [31:0] CHAIN_C  = 32'h98badcfe;
  localparam logic [31:0] CHAIN_D  = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amount by phase and low two bits of the round
  function automatic logic [4:0] rot_amt(input logic [1:0] phase, input logic [1:0] sel);
    logic [4:0] s;
    case (phase)
      2'd0: begin
        case (sel)
          2'd0: s = 5'd7;
          2'd1: s = 5'd12;
          2'd2: s = 5'd17;
          default: s = 5'd22;
        endcase
      end
      2'd1: begin
        case (sel)
          2'd0: s = 5'd5;
          2'd1: s = 5'd9;
          2'd2: s = 5'd14;
          default: s = 5'd20;
        endcase
      end
      2'd2: begin
        case (sel)
          2'd0: s = 5'd4;
          2'd1: s = 5'd11;
          2'd2: s = 5'd16;
          default: s = 5'd23;
        endcase
      end
      default: begin
        case (sel)
          2'd0: s = 5'd6;
          2'd1: s = 5'd10;
          2'd2: s = 5'd15;
          default: s = 5'd21;
        endcase
      end
    endcase
    return s;
  endfunction

  // message word picked by a round
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] k;
    logic [3:0] w;
    k = r[3:0];
    case (r[5:4])
      2'd0: w = k;
      2'd1: w = 4'd1 + 4'(k * 4'd5);
      2'd2: w = 4'd5 + 4'(k * 4'd3);
      default: w = 4'(k * 4'd7);
    endcase
    return w;
  endfunction

endpackage

>>> sv/md5_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_front: input queue
// Accepts items, drops idle ones, and buffers the rest for the core.
// ----------------------------------------------------------------------------
module md5_front import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  md5_item_t in_item,
  input  logic      push,
  output logic      full,
  output md5_item_t q_item,
  output logic      q_valid,
  input  logic      q_take
);

  md5_item_t  mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       do_push;
  logic       do_store;
  logic       do_pop;

  // items with neither a byte nor an end mark do nothing: not stored
  assign full     = fill[2];
  assign do_push  = push && !full;
  assign do_store = do_push && (in_item.byte_present || in_item.end_of_message);
  assign q_valid  = fill != 3'd0;
  assign do_pop   = q_take && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (do_store) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)   rd_ptr <= rd_ptr + 2'd1;
      if (do_store && !do_pop)      fill <= fill + 3'd1;
      else if (!do_store && do_pop) fill <= fill - 3'd1;
    end
  end

endmodule

>>> sv/md5_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_core: packing, padding and compression
// Packs bytes into the block, runs one round per cycle, emits the digest.
// ----------------------------------------------------------------------------
module md5_core import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md5_item_t   q_item,
  input  logic        q_valid,
  output logic        q_take,
  output logic [31:0] out_word,
  output logic [1:0]  out_idx,
  output logic        out_valid,
  input  logic        out_take
);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_CLR   = 7'b0000100,
    S_ZERO  = 7'b0001000,
    S_LEN   = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t      state;
  state_t      ret_state;
  logic        adding;
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [31:0] byte_count;
  logic        fin_pend;
  logic [4:0]  clr_idx;
  logic [5:0]  rnd;
  logic [1:0]  emit_idx;
  logic [31:0] ra, rb, rc, rd;

  logic [5:0]  pos;
  logic [31:0] f_val;
  logic [31:0] t_sum;
  logic [63:0] t_dbl;
  logic [31:0] t_rot;
  logic [3:0]  w_idx;
  logic [4:0]  sh;

  assign pos    = byte_count[5:0];
  assign q_take = (state == S_LOAD) && !adding;

  // one round of the compression
  always_comb begin
    case (rnd[5:4])
      2'd0: f_val = (rb & rc) | (~rb & rd);
      2'd1: f_val = (rb & rd) | (rc & ~rd);
      2'd2: f_val = rb ^ rc ^ rd;
      default: f_val = rc ^ (rb | ~rd);
    endcase
    w_idx = msg_index(rnd);
    sh    = rot_amt(rnd[5:4], rnd[1:0]);
    t_sum = ra + f_val + blk[w_idx] + ROUND_K[rnd];
    t_dbl = {t_sum, t_sum} << sh;
    t_rot = t_dbl[63:32] + rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      ret_state <= S_LOAD;
      adding    <= 1'b0;
      chain[0]  <= CHAIN_A;
      chain[1]  <= CHAIN_B;
      chain[2]  <= CHAIN_C;
      chain[3]  <= CHAIN_D;
      byte_count <= 32'd0;
      fin_pend  <= 1'b0;
      emit_idx  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_take) out_valid <= 1'b0;
      if (adding) begin
        // fold the working words into the chain, then resume
        adding   <= 1'b0;
        chain[0] <= chain[0] + ra;
        chain[1] <= chain[1] + rb;
        chain[2] <= chain[2] + rc;
        chain[3] <= chain[3] + rd;
        if (ret_state == S_LOAD && fin_pend) state <= S_PAD;
        else                                 state <= ret_state;
      end else begin
        case (state)
          // take one queued item
          S_LOAD: begin
            if (q_valid) begin
              if (q_item.byte_present) begin
                case (pos[1:0])
                  2'd0: blk[pos[5:2]] <= {24'd0, q_item.data_byte};
                  2'd1: blk[pos[5:2]] <= blk[pos[5:2]] | {16'd0, q_item.data_byte, 8'd0};
                  2'd2: blk[pos[5:2]] <= blk[pos[5:2]] | {8'd0, q_item.data_byte, 16'd0};
                  default: blk[pos[5:2]] <= blk[pos[5:2]] | {q_item.data_byte, 24'd0};
                endcase
                byte_count <= byte_count + 32'd1;
              end
              if (q_item.byte_present && pos == 6'd63) begin
                fin_pend  <= q_item.end_of_message;
                ret_state <= S_LOAD;
                ra <= chain[0]; rb <= chain[1]; rc <= chain[2]; rd <= chain[3];
                rnd   <= 6'd0;
                state <= S_ROUND;
              end else if (q_item.end_of_message) begin
                state <= S_PAD;
              end
            end
          end
          // end mark byte
          S_PAD: begin
            fin_pend <= 1'b0;
            case (pos[1:0])
              2'd0: blk[pos[5:2]] <= {24'd0, PAD_MARK};
              2'd1: blk[pos[5:2]] <= blk[pos[5:2]] | {16'd0, PAD_MARK, 8'd0};
              2'd2: blk[pos[5:2]] <= blk[pos[5:2]] | {8'd0, PAD_MARK, 16'd0};
              default: blk[pos[5:2]] <= blk[pos[5:2]] | {PAD_MARK, 24'd0};
            endcase
            clr_idx <= {1'b0, pos[5:2]} + 5'd1;
            state   <= S_CLR;
          end
          // clear the words after the end mark
          S_CLR: begin
            if (clr_idx[4]) begin
              if (pos >= 6'd56) begin
                ret_state <= S_ZERO;
                clr_idx   <= 5'd0;
                ra <= chain[0]; rb <= chain[1]; rc <= chain[2]; rd <= chain[3];
                rnd   <= 6'd0;
                state <= S_ROUND;
              end else begin
                state <= S_LEN;
              end
            end else begin
              blk[clr_idx[3:0]] <= 32'd0;
              clr_idx <= clr_idx + 5'd1;
            end
          end
          // zero the whole extra block
          S_ZERO: begin
            if (clr_idx[4]) begin
              state <= S_LEN;
            end else begin
              blk[clr_idx[3:0]] <= 32'd0;
              clr_idx <= clr_idx + 5'd1;
            end
          end
          // bit length and final compression
          S_LEN: begin
            blk[14]   <= {byte_count[28:0], 3'd0};
            blk[15]   <= {29'd0, byte_count[31:29]};
            ret_state <= S_EMIT;
            ra <= chain[0]; rb <= chain[1]; rc <= chain[2]; rd <= chain[3];
            rnd   <= 6'd0;
            state <= S_ROUND;
          end
          S_ROUND: begin
            ra <= rd;
            rd <= rc;
            rc <= rb;
            rb <= t_rot;
            rnd <= rnd + 6'd1;
            if (rnd == 6'd63) adding <= 1'b1;
          end
          // hand out the four digest words
          S_EMIT: begin
            if (!out_valid || out_take) begin
              out_valid <= 1'b1;
              out_word  <= chain[emit_idx];
              out_idx   <= emit_idx;
              emit_idx  <= emit_idx + 2'd1;
              if (emit_idx == 2'd3) begin
                chain[0]   <= CHAIN_A;
                chain[1]   <= CHAIN_B;
                chain[2]   <= CHAIN_C;
                chain[3]   <= CHAIN_D;
                byte_count <= 32'd0;
                state      <= S_LOAD;
              end
            end
          end
          default: state <= S_LOAD;
        endcase
      end
    end
  end

endmodule

>>> sv/md5_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_digest: MD5 digest over a byte stream
// Input queue in front, compression core behind, digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: push with data_byte, byte_present, end_of_message; a
//   transfer happens when push is high and full is low. A four-entry queue
//   takes items while the core works. Items with neither flag are dropped.
//   Result channel: while empty is low, digest_word/word_index/last_word show
//   the oldest word; pop transfers it. Four words follow each end mark,
//   word A first, last_word set on word D.
//   Throughput: one byte per cycle into the queue while full is low; the core
//   drains one byte a cycle while the queue holds items, but takes none while
//   it compresses a full 64-byte block (64 rounds plus the chain add, one
//   round per cycle). Finishing runs padding, clearing and length setup,
//   one or two compressed blocks, then hands out the digest words.
//   When the receiver stalls the core holds the next word and stops; the
//   queue fills and full rises. Reset empties the queue and output and loads
//   the initial chaining values.
// ----------------------------------------------------------------------------
module md5_message_digest import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  input  logic        push,
  output logic        full,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  logic        pop
);

  md5_item_t in_item;
  md5_item_t q_item;
  logic      q_valid;
  logic      q_take;
  logic      out_valid;

  assign in_item = '{data_byte: data_byte, byte_present: byte_present,
                     end_of_message: end_of_message};

  md5_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .q_item(q_item), .q_valid(q_valid), .q_take(q_take)
  );

  md5_core u_core (
    .clk(clk), .rst(rst), .q_item(q_item), .q_valid(q_valid), .q_take(q_take),
    .out_word(digest_word), .out_idx(word_index), .out_valid(out_valid),
    .out_take(pop && out_valid)
  );

  assign empty     = !out_valid;
  assign last_word = word_index == 2'd3;

endmodule
